// File: rtl/mlfd_pkg.sv
// Shared types and constants for the marker/length frame deframer.
`default_nettype none

package mlfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned FLEN_W    = 10;
  localparam int unsigned BSEEN_W   = 20;
  localparam int unsigned FSEEN_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 1'd1;

  localparam logic [BYTE_W-1:0]  START_ONE_RST = 8'd148;
  localparam logic [BYTE_W-1:0]  START_TWO_RST = 8'd195;
  localparam logic [FSEEN_W-1:0] FRAMES_MAX    = 16'hFFFF;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  payload_byte;
    logic               payload_valid;
    logic               last_of_frame;
    logic [FLEN_W-1:0]  frame_length;
    logic               length_rejected;
    logic [BSEEN_W-1:0] bytes_seen;
    logic [FSEEN_W-1:0] frames_seen;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/mlfd_in_stage.sv
// Input register for received items.
`default_nettype none

module mlfd_in_stage
  import mlfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       held_valid,
  output item_t      held_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !advance);
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mlfd_core.sv
// Deframer state, marker registers and per-byte next-state logic.
`default_nettype none

module mlfd_core
  import mlfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD      = 512,
  parameter int unsigned BYTE_COUNT_LIMIT = 1000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire item_t                item,
  input  wire logic                 advance,
  output result_t                   result
);

  localparam int unsigned RC_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BC_W = $clog2(BYTE_COUNT_LIMIT + 1);

  typedef enum logic [2:0] {
    PH_MARK1 = 3'd0,
    PH_MARK2 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [RC_W-1:0]   rcount_r, rcount_nxt;
  logic [BC_W-1:0]   bcount_r, bcount_nxt;
  logic [FSEEN_W-1:0] fcount_r, fcount_nxt;
  logic [BYTE_W-1:0] start_one_r, start_two_r;
  logic [LEN_W-1:0]  len_full;
  logic [RC_W-1:0]   rcount_inc;
  logic [31:0]       bcount_ext;

  assign len_full   = {length_r[LEN_W-1:BYTE_W], item.rx_byte};
  assign rcount_inc = rcount_r + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    rcount_nxt = rcount_r;
    bcount_nxt = bcount_r;
    fcount_nxt = fcount_r;
    result     = '0;
    if (item.op == OP_RESTART) begin
      phase_nxt  = PH_MARK1;
      length_nxt = '0;
      rcount_nxt = '0;
      bcount_nxt = '0;
      fcount_nxt = '0;
    end else begin
      if (bcount_r < BC_W'(BYTE_COUNT_LIMIT)) begin
        bcount_nxt = bcount_r + 1'b1;
      end
      case (phase_r)
        PH_MARK2: begin
          phase_nxt = (item.rx_byte == start_two_r) ? PH_LENHI : PH_MARK1;
        end
        PH_LENHI: begin
          length_nxt = {item.rx_byte, {BYTE_W{1'b0}}};
          phase_nxt  = PH_LENLO;
        end
        PH_LENLO: begin
          length_nxt = len_full;
          if (len_full == '0 || len_full > LEN_W'(MAX_PAYLOAD)) begin
            result.length_rejected = 1'b1;
            phase_nxt              = PH_MARK1;
          end else begin
            rcount_nxt = '0;
            phase_nxt  = PH_DATA;
          end
        end
        PH_DATA: begin
          rcount_nxt           = rcount_inc;
          result.payload_byte  = item.rx_byte;
          result.payload_valid = 1'b1;
          result.frame_length  = length_r[FLEN_W-1:0];
          if (LEN_W'(rcount_inc) >= length_r) begin
            result.last_of_frame = 1'b1;
            if (fcount_r < FRAMES_MAX) begin
              fcount_nxt = fcount_r + 1'b1;
            end
            phase_nxt = PH_MARK1;
          end
        end
        default: begin
          phase_nxt = (item.rx_byte == start_one_r) ? PH_MARK2 : PH_MARK1;
        end
      endcase
    end
    bcount_ext         = 32'(bcount_nxt);
    result.bytes_seen  = bcount_ext[BSEEN_W-1:0];
    result.frames_seen = fcount_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MARK1;
      length_r    <= '0;
      rcount_r    <= '0;
      bcount_r    <= '0;
      fcount_r    <= '0;
      start_one_r <= START_ONE_RST;
      start_two_r <= START_TWO_RST;
    end else begin
      if (advance) begin
        phase_r  <= phase_nxt;
        length_r <= length_nxt;
        rcount_r <= rcount_nxt;
        bcount_r <= bcount_nxt;
        fcount_r <= fcount_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ONE: start_one_r <= cfg_wdata;
          REG_START_TWO: start_two_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == OP_RESTART |=>
      phase_r == PH_MARK1 && bcount_r == '0 && fcount_r == '0)
    else $error("restart did not clear deframer state");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> LEN_W'(rcount_r) < length_r)
    else $error("payload count reached frame length while still in payload");

  a_payload_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    result.payload_valid || result.last_of_frame |-> phase_r == PH_DATA)
    else $error("payload flagged outside the payload phase");

  a_reject_only_on_length: assert property (@(posedge clk) disable iff (!rst_n)
    result.length_rejected |-> phase_r == PH_LENLO && !result.payload_valid)
    else $error("length rejection outside the length phase");

  a_byte_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.op == OP_BYTE && bcount_r < BC_W'(BYTE_COUNT_LIMIT) |=>
      bcount_r == $past(bcount_r) + 1'b1)
    else $error("byte counter failed to step");

endmodule

`default_nettype wire

// File: rtl/mlfd_out_stage.sv
// Result register towards the output channel.
`default_nettype none

module mlfd_out_stage
  import mlfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         can_load,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign valid_nxt  = load || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

`default_nettype wire

// File: rtl/magic_length_frame_deframer_unit.sv
// Top level of the marker/length frame deframer.
//
// Input channel (in_valid/in_ready): one item per transfer, either a received
// byte (in_op clear) or a restart (in_op set) that clears the counters and
// returns the parser to marker hunting.
// Output channel (out_valid/out_ready): exactly one result per input item, in
// order: the payload byte with its valid and last flags, the frame length, a
// rejected-length flag and the byte and frame counters after that item.
// Configuration: cfg_we writes cfg_wdata into the marker byte picked by
// cfg_index (0 first marker, 1 second marker). The user writes it only while
// idle; the block itself does not enforce this. An item passes from the input
// register through the combinational state update into the result register.
// Throughput: one item per cycle while the receiver takes every result.
// Reset (rst_n low, synchronous): both stages empty, parser hunting, counters
// zero, markers back to 148 and 195.
// When the receiver stalls the result register holds; the input register then
// takes one more item and in_ready falls until the result is taken.
`default_nettype none

module magic_length_frame_deframer_unit
  import mlfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD      = 512,
  parameter int unsigned BYTE_COUNT_LIMIT = 1000000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_W-1:0]         out_payload_byte,
  output logic                      out_payload_valid,
  output logic                      out_last_of_frame,
  output logic [FLEN_W-1:0]         out_frame_length,
  output logic                      out_length_rejected,
  output logic [BSEEN_W-1:0]        out_bytes_seen,
  output logic [FSEEN_W-1:0]        out_frames_seen
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    advance;
  result_t core_result;
  result_t out_result;

  assign in_item.op      = in_op;
  assign in_item.rx_byte = in_rx_byte;
  assign advance         = held_valid && can_load;

  mlfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mlfd_core #(
    .MAX_PAYLOAD      (MAX_PAYLOAD),
    .BYTE_COUNT_LIMIT (BYTE_COUNT_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (held_item),
    .advance   (advance),
    .result    (core_result)
  );

  mlfd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (core_result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_payload_byte    = out_result.payload_byte;
  assign out_payload_valid   = out_result.payload_valid;
  assign out_last_of_frame   = out_result.last_of_frame;
  assign out_frame_length    = out_result.frame_length;
  assign out_length_rejected = out_result.length_rejected;
  assign out_bytes_seen      = out_result.bytes_seen;
  assign out_frames_seen     = out_result.frames_seen;

endmodule

`default_nettype wire

// File: verif/magic_length_frame_deframer_unit_test.sv
// Self-checking testbench for the marker/length frame deframer.
`timescale 1ns / 1ps

module magic_length_frame_deframer_unit_test;
  import mlfd_pkg::*;

  localparam int unsigned MAX_PAYLOAD       = 512;
  localparam int unsigned BYTE_COUNT_LIMIT  = 1000000;
  localparam int unsigned MAX_GAP           = 5;
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned PRINT_LIMIT       = 100;

  typedef enum logic [2:0] {HUNT_ONE, HUNT_TWO, LEN_HIGH, LEN_LOW, PAYLOAD} parse_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_ONE;
  logic [BYTE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_BYTE;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] out_payload_byte;
  logic out_payload_valid;
  logic out_last_of_frame;
  logic [FLEN_W-1:0] out_frame_length;
  logic out_length_rejected;
  logic [BSEEN_W-1:0] out_bytes_seen;
  logic [FSEEN_W-1:0] out_frames_seen;

  // parser mirror
  parse_phase_t parse_phase;
  logic [LEN_W-1:0] length_reg;
  logic [FLEN_W-1:0] received_count;
  logic [BSEEN_W-1:0] bytes_count;
  logic [FSEEN_W-1:0] frames_count;
  logic [BYTE_W-1:0] marker_one;
  logic [BYTE_W-1:0] marker_two;

  item_t pending_bytes[$];
  result_t expected_deframed[$];
  item_t loaded;
  result_t want;
  bit sender_idles;
  bit receiver_idles;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned stall;
  int unsigned items_queued;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;

  magic_length_frame_deframer_unit #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .BYTE_COUNT_LIMIT(BYTE_COUNT_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload_byte(out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_last_of_frame(out_last_of_frame),
    .out_frame_length(out_frame_length),
    .out_length_rejected(out_length_rejected),
    .out_bytes_seen(out_bytes_seen),
    .out_frames_seen(out_frames_seen)
  );

  always #5 clk = ~clk;

  function automatic result_t deframe_byte(input item_t it);
    result_t r;
    r = '0;
    if (it.op == OP_RESTART) begin
      bytes_count = '0;
      frames_count = '0;
      length_reg = '0;
      received_count = '0;
      parse_phase = HUNT_ONE;
    end else begin
      if (bytes_count < BYTE_COUNT_LIMIT) bytes_count = bytes_count + 1'b1;
      case (parse_phase)
        HUNT_TWO: begin
          parse_phase = (it.rx_byte == marker_two) ? LEN_HIGH : HUNT_ONE;
        end
        LEN_HIGH: begin
          length_reg = {it.rx_byte, 8'h00};
          parse_phase = LEN_LOW;
        end
        LEN_LOW: begin
          length_reg[7:0] = it.rx_byte;
          if (length_reg == 0 || length_reg > MAX_PAYLOAD) begin
            r.length_rejected = 1'b1;
            parse_phase = HUNT_ONE;
          end else begin
            received_count = '0;
            parse_phase = PAYLOAD;
          end
        end
        PAYLOAD: begin
          received_count = received_count + 1'b1;
          r.payload_byte = it.rx_byte;
          r.payload_valid = 1'b1;
          r.frame_length = length_reg[FLEN_W-1:0];
          if (received_count >= length_reg) begin
            r.last_of_frame = 1'b1;
            if (frames_count < FRAMES_MAX) frames_count = frames_count + 1'b1;
            parse_phase = HUNT_ONE;
          end
        end
        default: begin
          parse_phase = (it.rx_byte == marker_one) ? HUNT_TWO : HUNT_ONE;
        end
      endcase
    end
    r.bytes_seen = bytes_count;
    r.frames_seen = frames_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    if (error_count < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, exp_val);
    error_count++;
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back({OP_BYTE, b});
    items_queued++;
  endtask

  task automatic queue_restart();
    logic [BYTE_W-1:0] junk;
    junk = BYTE_W'($urandom_range(0, 255));
    pending_bytes.push_back({OP_RESTART, junk});
    items_queued++;
  endtask

  task automatic queue_header(input logic [LEN_W-1:0] len);
    queue_byte(marker_one);
    queue_byte(marker_two);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
  endtask

  task automatic queue_frame(input int unsigned len);
    queue_header(LEN_W'(len));
    repeat (len) queue_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic queue_random_traffic(input int unsigned target);
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    logic [BYTE_W-1:0] wrong;
    first = items_queued;
    while (items_queued - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 39) == 0) len = $urandom_range(17, MAX_PAYLOAD);
        else len = $urandom_range(1, 16);
        queue_frame(len);
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0: len = 0;
          1: len = MAX_PAYLOAD + 1;
          2: len = 16'hFFFF;
          default: len = $urandom_range(MAX_PAYLOAD + 1, 16'hFFFF);
        endcase
        queue_header(LEN_W'(len));
      end else if (pick < 75) begin
        queue_byte(marker_one);
        do wrong = BYTE_W'($urandom_range(0, 255)); while (wrong == marker_two);
        queue_byte(wrong);
      end else if (pick < 80) begin
        // first marker again in the second slot: not taken as a fresh start
        queue_byte(marker_one);
        queue_byte(marker_one);
        queue_byte(marker_two);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) queue_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        len = $urandom_range(2, 16);
        queue_header(LEN_W'(len));
        repeat ($urandom_range(0, len - 1)) queue_byte(BYTE_W'($urandom_range(0, 255)));
        queue_restart();
      end else if (pick < 97) begin
        queue_byte(marker_one);
        if ($urandom_range(0, 1)) queue_byte(marker_two);
        if ($urandom_range(0, 1)) queue_byte(BYTE_W'($urandom_range(0, 255)));
        queue_restart();
      end else begin
        queue_restart();
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_deframed.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_ONE) marker_one = val;
    else marker_two = val;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) expected_deframed.push_back(deframe_byte({in_op, in_rx_byte}));
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_bytes.size() != 0) begin
          loaded = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_op <= loaded.op;
          in_rx_byte <= loaded.rx_byte;
          send_wait <= sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_deframed.size() == 0) begin
        report_mismatch("transfer with nothing expected", out_bytes_seen, 0);
      end else begin
        want = expected_deframed.pop_front();
        if (out_payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", out_payload_byte, want.payload_byte);
        if (out_payload_valid !== want.payload_valid)
          report_mismatch("payload_valid", out_payload_valid, want.payload_valid);
        if (out_last_of_frame !== want.last_of_frame)
          report_mismatch("last_of_frame", out_last_of_frame, want.last_of_frame);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_length_rejected !== want.length_rejected)
          report_mismatch("length_rejected", out_length_rejected, want.length_rejected);
        if (out_bytes_seen !== want.bytes_seen)
          report_mismatch("bytes_seen", out_bytes_seen, want.bytes_seen);
        if (out_frames_seen !== want.frames_seen)
          report_mismatch("frames_seen", out_frames_seen, want.frames_seen);
      end
      results_seen++;
      stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      out_ready <= (stall == 0);
      recv_wait <= (stall == 0) ? 0 : stall - 1;
    end else if (!out_ready) begin
      if (recv_wait == 0) out_ready <= 1'b1;
      else recv_wait <= recv_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("magic_length_frame_deframer_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] shared;
    parse_phase = HUNT_ONE;
    length_reg = '0;
    received_count = '0;
    bytes_count = '0;
    frames_count = '0;
    marker_one = START_ONE_RST;
    marker_two = START_TWO_RST;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset markers
    queue_restart();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_header(16'd1);
    queue_byte(8'hFF);
    queue_byte(marker_one);
    queue_byte(marker_one);
    queue_byte(marker_two);
    queue_byte(8'h00);
    queue_byte(8'h01);
    queue_header(16'd0);
    queue_header(LEN_W'(MAX_PAYLOAD + 1));
    queue_header(16'd3);
    queue_byte(8'hAA);
    queue_restart();
    wait_drained();

    write_marker(REG_START_ONE, 8'h00);
    write_marker(REG_START_TWO, 8'hFF);
    queue_frame(MAX_PAYLOAD);
    queue_header(16'hFFFF);
    queue_random_traffic(320);
    wait_drained();

    write_marker(REG_START_ONE, 8'hFF);
    write_marker(REG_START_TWO, 8'h00);
    queue_random_traffic(320);
    wait_drained();

    shared = BYTE_W'($urandom_range(0, 255));
    write_marker(REG_START_ONE, shared);
    write_marker(REG_START_TWO, shared);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    queue_random_traffic(320);
    wait_drained();

    write_marker(REG_START_ONE, BYTE_W'($urandom_range(0, 255)));
    write_marker(REG_START_TWO, BYTE_W'($urandom_range(0, 255)));
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    queue_random_traffic(320);
    wait_drained();

    write_marker(REG_START_ONE, START_ONE_RST);
    write_marker(REG_START_TWO, START_TWO_RST);
    queue_byte(marker_one);
    queue_restart();
    queue_frame(2);
    wait_drained();

    if (error_count == 0) begin
      $display("magic_length_frame_deframer_unit regression: pass");
    end else begin
      $display("magic_length_frame_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
